### sv/p2p_pkg.sv
// Shared constants for the peak-to-peak level meter.
// No dependencies; imported by every module of the block.
package p2p_pkg;

    localparam int SAMPLE_WIDTH = 32;

    localparam int P2P_W   = 31;
    localparam int NORM_W  = 24;
    localparam int DB_W    = 16;
    localparam int FRAC_W  = 16;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 64;

    localparam logic [P2P_W-1:0]  P2P_MAX  = '1;
    localparam logic [NORM_W-1:0] NORM_MAX = '1;

    // 20*log10(2) in Q.16
    localparam logic signed [MUL_W-1:0] DB_K = 33'sd394566;

    // configuration register indexes
    localparam logic [2:0] CFG_WINDOW_LENGTH = 3'd0;
    localparam logic [2:0] CFG_GAIN          = 3'd1;
    localparam logic [2:0] CFG_FULL_SCALE    = 3'd2;
    localparam logic [2:0] CFG_REFERENCE     = 3'd3;
    localparam logic [2:0] CFG_DB_OFFSET     = 3'd4;

    // configuration reset values
    localparam logic [15:0]        RST_WINDOW_LENGTH = 16'd441;
    localparam logic [7:0]         RST_GAIN          = 8'd1;
    localparam logic [23:0]        RST_FULL_SCALE    = 24'd8388607;
    localparam logic [23:0]        RST_REFERENCE     = 24'd1;
    localparam logic signed [15:0] RST_DB_OFFSET     = 16'sd0;

endpackage

### sv/p2p_mul.sv
// Shared signed multiplier with a registered product.
// Depends on p2p_pkg for operand and product widths.
module p2p_mul import p2p_pkg::*; (
    input  logic                    i_clk,
    input  logic signed [MUL_W-1:0] i_a,
    input  logic signed [MUL_W-1:0] i_b,
    output logic [PROD_W-1:0]       o_prod
);

    logic signed [2*MUL_W-1:0] w_full;
    logic [PROD_W-1:0]         r_prod;

    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[PROD_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

### sv/p2p_window.sv
// Running min/max tracker and sample counter for one measurement window.
// Depends on p2p_pkg for the sample width.
module p2p_window import p2p_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [31:0] i_sample,
    input  logic [15:0] i_window_length,
    output logic        o_close,
    output logic [31:0] o_diff
);

    logic signed [SAMPLE_WIDTH-1:0] w_raw;
    logic signed [31:0]             w_s;
    logic signed [31:0]             r_min, n_min;
    logic signed [31:0]             r_max, n_max;
    logic [15:0]                    r_cnt;
    logic [16:0]                    w_cnt_inc;
    logic [15:0]                    w_len;
    logic signed [32:0]             w_diff;
    logic [31:0]                    r_diff;

    assign w_raw     = i_sample[SAMPLE_WIDTH-1:0];
    assign w_s       = 32'(w_raw);
    assign n_min     = (w_s < r_min) ? w_s : r_min;
    assign n_max     = (w_s > r_max) ? w_s : r_max;
    assign w_cnt_inc = {1'b0, r_cnt} + 17'd1;
    assign w_len     = (i_window_length == 16'd0) ? 16'd1 : i_window_length;
    assign o_close   = (w_cnt_inc >= {1'b0, w_len});
    assign w_diff    = 33'(n_max) - 33'(n_min);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 32'sh7FFF_FFFF;
            r_max <= 32'sh8000_0000;
            r_cnt <= '0;
        end else if (i_accept) begin
            if (o_close) begin
                r_min <= 32'sh7FFF_FFFF;
                r_max <= 32'sh8000_0000;
                r_cnt <= '0;
            end else begin
                r_min <= n_min;
                r_max <= n_max;
                r_cnt <= w_cnt_inc[15:0];
            end
        end
    end

    // hold the span of the closing window for the sequencer
    always_ff @(posedge i_clk) begin
        if (i_accept && o_close) begin
            r_diff <= w_diff[31:0];
        end
    end

    assign o_diff = r_diff;

endmodule

### sv/p2p_div.sv
// Restoring divider, one quotient bit per cycle, for the normalized level.
// Depends on p2p_pkg for field widths.
module p2p_div import p2p_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [P2P_W-1:0]  i_p2p,
    input  logic [23:0]       i_full_scale,
    output logic              o_busy,
    output logic [NORM_W-1:0] o_quot
);

    logic              r_busy;
    logic [4:0]        r_cnt;
    logic [23:0]       r_rem;
    logic [23:0]       r_bits;
    logic [NORM_W-1:0] r_quot;
    logic [24:0]       w_trial;
    logic              w_ge;
    logic              w_sat;

    assign w_trial = {r_rem, r_bits[23]};
    assign w_ge    = (w_trial >= {1'b0, i_full_scale});
    // quotient overflows 24 bits exactly when p2p >= full_scale * 2^8
    assign w_sat   = ({1'b0, i_p2p} >= {i_full_scale, 8'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= (i_p2p != '0) && !w_sat;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd23) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_p2p[30:8]};
            r_bits <= {i_p2p[7:0], 16'd0};
            if (i_p2p == '0) begin
                r_quot <= '0;
            end else if (w_sat) begin
                r_quot <= NORM_MAX;
            end else begin
                r_quot <= '0;
            end
        end else if (r_busy) begin
            r_bits <= {r_bits[22:0], 1'b0};
            if (w_ge) begin
                r_rem <= 24'(w_trial - {1'b0, i_full_scale});
            end else begin
                r_rem <= w_trial[23:0];
            end
            r_quot <= {r_quot[NORM_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

### sv/peak_to_peak_level_meter.sv
// Peak-to-peak level meter, one audio channel; top level with sequencer and config.
// Samples that do not close a window are taken one per cycle while the sequencer is idle.
// A window-closing sample stalls the input until the sequencer is done (gain product, two log2 passes of
// 5 shift steps and 16 squarings each, dB product, round and offset, output load); its result is
// valid after the output load, sooner when the span is zero, later while a result still waits.
// Synchronous active-low reset restores config defaults, restarts min/max/count and control.
module peak_to_peak_level_meter import p2p_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [31:0]            i_sample,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [P2P_W-1:0]       o_peak_to_peak,
    output logic [NORM_W-1:0]      o_normalized_power,
    output logic signed [DB_W-1:0] o_power_db,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [23:0]            i_cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GAIN = 4'd1;  // diff * gain into the multiplier
    localparam logic [3:0] S_SAT  = 4'd2;  // clamp p2p, start divider and first log
    localparam logic [3:0] S_NORM = 4'd3;  // leading-one search, 16/8/4/2/1 bit steps
    localparam logic [3:0] S_SQ   = 4'd4;  // square the mantissa
    localparam logic [3:0] S_SQW  = 4'd5;  // take one fraction bit from the square
    localparam logic [3:0] S_DB   = 4'd6;  // log difference times 20*log10(2)
    localparam logic [3:0] S_DBW  = 4'd7;  // round, add offset, saturate
    localparam logic [3:0] S_OUT  = 4'd8;  // wait for divider and output slot

    // configuration registers
    logic [15:0]        r_window_length;
    logic [7:0]         r_gain;
    logic [23:0]        r_full_scale;
    logic [23:0]        r_reference;
    logic signed [15:0] r_db_offset;

    logic [3:0]  r_state;
    logic        w_accept;
    logic        w_close;
    logic [31:0] w_diff;

    // log2 datapath
    logic [31:0]         r_m;
    logic [4:0]          r_n;
    logic [FRAC_W-1:0]   r_frac;
    logic [2:0]          r_step;
    logic [3:0]          r_iter;
    logic                r_which;
    logic [20:0]         r_lp;
    logic [20:0]         r_lr;

    logic [P2P_W-1:0]       r_p2p;
    logic signed [DB_W-1:0] r_db;

    logic [P2P_W-1:0]       r_o_p2p;
    logic [NORM_W-1:0]      r_o_norm;
    logic signed [DB_W-1:0] r_o_db;
    logic                   r_o_valid;

    logic signed [MUL_W-1:0] w_mul_a;
    logic signed [MUL_W-1:0] w_mul_b;
    logic [PROD_W-1:0]       w_prod;

    logic              w_div_start;
    logic              w_div_busy;
    logic [NORM_W-1:0] w_div_quot;

    logic [P2P_W-1:0]    w_sat_p2p;
    logic [4:0]          w_sh;
    logic                w_hi_zero;
    logic [32:0]         w_sq;
    logic [31:0]         w_m_next;
    logic [FRAC_W-1:0]   w_frac_next;
    logic signed [21:0]  w_d;
    logic signed [63:0]  w_round;
    logic signed [17:0]  w_lvl;
    logic signed [18:0]  w_sum;
    logic signed [DB_W-1:0] w_db_sat;

    assign w_accept    = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= RST_WINDOW_LENGTH;
            r_gain          <= RST_GAIN;
            r_full_scale    <= RST_FULL_SCALE;
            r_reference     <= RST_REFERENCE;
            r_db_offset     <= RST_DB_OFFSET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH: r_window_length <= i_cfg_data[15:0];
                CFG_GAIN:          r_gain          <= i_cfg_data[7:0];
                CFG_FULL_SCALE:    r_full_scale    <= i_cfg_data;
                CFG_REFERENCE:     r_reference     <= i_cfg_data;
                CFG_DB_OFFSET:     r_db_offset     <= $signed(i_cfg_data[15:0]);
                default: begin
                end
            endcase
        end
    end

    p2p_window u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_sample        (i_sample),
        .i_window_length (r_window_length),
        .o_close         (w_close),
        .o_diff          (w_diff)
    );

    // steer the shared multiplier by sequencer state
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_GAIN: begin
                w_mul_a = $signed({1'b0, w_diff});
                w_mul_b = $signed({25'd0, r_gain});
            end
            S_SQ: begin
                w_mul_a = $signed({1'b0, r_m});
                w_mul_b = $signed({1'b0, r_m});
            end
            S_DB: begin
                w_mul_a = 33'(w_d);
                w_mul_b = DB_K;
            end
            default: begin
            end
        endcase
    end

    p2p_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_div_start = (r_state == S_SAT);

    p2p_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_div_start),
        .i_p2p        (w_sat_p2p),
        .i_full_scale (r_full_scale),
        .o_busy       (w_div_busy),
        .o_quot       (w_div_quot)
    );

    // clamp the gained span to 31 bits
    assign w_sat_p2p = (w_prod[63:31] != '0) ? P2P_MAX : w_prod[30:0];

    // leading-one search: shift by 16, 8, 4, 2, 1 when the top bits are clear
    always_comb begin
        case (r_step)
            3'd0:    w_sh = 5'd16;
            3'd1:    w_sh = 5'd8;
            3'd2:    w_sh = 5'd4;
            3'd3:    w_sh = 5'd2;
            default: w_sh = 5'd1;
        endcase
    end
    assign w_hi_zero = ((r_m & ~(32'hFFFF_FFFF >> w_sh)) == '0);

    // one fraction bit per squaring of the Q1.31 mantissa
    assign w_sq        = w_prod[63:31];
    assign w_m_next    = w_sq[32] ? w_sq[32:1] : w_sq[31:0];
    assign w_frac_next = {r_frac[FRAC_W-2:0], w_sq[32]};

    // dB: round the Q.16*Q.16 product back to Q8.8, add offset, saturate
    assign w_d      = $signed({1'b0, r_lp}) - $signed({1'b0, r_lr});
    assign w_round  = $signed(w_prod) + 64'sd8388608;
    assign w_lvl    = w_round[41:24];
    assign w_sum    = 19'(w_lvl) + 19'(r_db_offset);
    assign w_db_sat = (w_sum > 19'sd32767)  ? 16'sh7FFF :
                      (w_sum < -19'sd32768) ? 16'sh8000 : w_sum[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_close) begin
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: r_state <= S_SAT;
                S_SAT: begin
                    // zero span skips both logs
                    r_state <= (w_sat_p2p == '0) ? S_OUT : S_NORM;
                end
                S_NORM: begin
                    if (r_step == 3'd4) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: r_state <= S_SQW;
                S_SQW: begin
                    if (r_iter == 4'd15) begin
                        r_state <= r_which ? S_DB : S_NORM;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_DB:  r_state <= S_DBW;
                S_DBW: r_state <= S_OUT;
                S_OUT: begin
                    if (!w_div_busy && !r_o_valid) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers, advanced by the sequencer
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_SAT: begin
                r_p2p   <= w_sat_p2p;
                r_db    <= '0;
                r_m     <= {1'b0, w_sat_p2p};
                r_n     <= 5'd31;
                r_step  <= '0;
                r_which <= 1'b0;
            end
            S_NORM: begin
                if (w_hi_zero) begin
                    r_m <= r_m << w_sh;
                    r_n <= r_n - w_sh;
                end
                r_step <= r_step + 3'd1;
                r_iter <= '0;
                r_frac <= '0;
            end
            S_SQW: begin
                r_frac <= w_frac_next;
                r_iter <= r_iter + 4'd1;
                if (r_iter == 4'd15) begin
                    if (r_which) begin
                        r_m  <= w_m_next;
                        r_lr <= {r_n, w_frac_next};
                    end else begin
                        // load the reference for the second log; zero reads as one
                        r_lp    <= {r_n, w_frac_next};
                        r_m     <= (r_reference == '0) ? 32'd1 : {8'd0, r_reference};
                        r_n     <= 5'd31;
                        r_step  <= '0;
                        r_which <= 1'b1;
                    end
                end else begin
                    r_m <= w_m_next;
                end
            end
            S_DBW: r_db <= w_db_sat;
            default: begin
            end
        endcase
    end

    // output register: load when the slot is free, drop on a taken transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_OUT && !w_div_busy && !r_o_valid) begin
            r_o_valid <= 1'b1;
        end else if (r_o_valid && !i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && !w_div_busy && !r_o_valid) begin
            r_o_p2p  <= r_p2p;
            r_o_norm <= w_div_quot;
            r_o_db   <= r_db;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_peak_to_peak     = r_o_p2p;
    assign o_normalized_power = r_o_norm;
    assign o_power_db         = r_o_db;

endmodule
